// ----- hw/rtl/rbcl_pkg.sv -----
// Shared types, constants and helper functions of the red blob center locator.
`default_nettype none

package rbcl_pkg;

    localparam int COLOR_W     = 8;
    localparam int COORD_W     = 10;
    localparam int COUNT_W     = 21;
    localparam int TIME_W      = 16;
    localparam int COORD_LIMIT = 1024;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] MIN_RESET = COUNT_W'(100);

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] line;
        logic               frame_end;
        logic [TIME_W-1:0]  frame_time;
    } pixel_t;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (int'(v) >= COORD_LIMIT)
        begin
            r = COORD_W'(COORD_LIMIT - 1);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] midpoint(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        logic signed [COORD_W:0] diff;
        logic signed [COORD_W:0] half;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        half = (diff + $signed({{COORD_W{1'b0}}, diff[COORD_W]})) >>> 1;
        return a + half[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/red_blob_center_locator.sv -----
// Top level of the red blob center locator.
`default_nettype none

// Takes one RGB pixel item per clock, unless stalled, in raster order and, on
// the pixel marked frame_end, delivers one frame result: day flag, center of
// the red region, saturating red count and the frame time. A pixel is held in
// the input register until the tracker folds it into the tracking state; the
// frame result is then registered in the output register and held there
// while out_stall is high. Pixel items are taken every cycle except while a
// frame-end pixel waits, which it does only while the previous result is
// still held stalled in the output register.
// min_red_pixels is written through cfg_we/cfg_wdata and resets to 100.
module red_blob_center_locator
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rbcl_pkg::COUNT_W-1:0]  cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [rbcl_pkg::COLOR_W-1:0]  red,
    input  wire logic [rbcl_pkg::COLOR_W-1:0]  green,
    input  wire logic [rbcl_pkg::COLOR_W-1:0]  blue,
    input  wire logic [rbcl_pkg::COORD_W-1:0]  column,
    input  wire logic [rbcl_pkg::COORD_W-1:0]  line,
    input  wire logic                          frame_end,
    input  wire logic [rbcl_pkg::TIME_W-1:0]   frame_time,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               is_day,
    output logic [rbcl_pkg::COORD_W-1:0]       center_x,
    output logic [rbcl_pkg::COORD_W-1:0]       center_y,
    output logic [rbcl_pkg::COUNT_W-1:0]       red_total,
    output logic [rbcl_pkg::TIME_W-1:0]        logged_time
);
    import rbcl_pkg::*;

    logic [COUNT_W-1:0] min_reg;
    pixel_t             in_pixel;
    pixel_t             pix;
    logic               pix_valid;
    logic               advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_RESET;
        end
        else if (cfg_we)
        begin
            min_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        in_pixel.red        = red;
        in_pixel.green      = green;
        in_pixel.blue       = blue;
        in_pixel.column     = column;
        in_pixel.line       = line;
        in_pixel.frame_end  = frame_end;
        in_pixel.frame_time = frame_time;
    end

    rbcl_pixel_reg u_pixel_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_pixel  (in_pixel),
        .advance   (advance),
        .pix_valid (pix_valid),
        .pix       (pix)
    );

    rbcl_tracker u_tracker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_valid      (pix_valid),
        .pix            (pix),
        .min_red_pixels (min_reg),
        .advance        (advance),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_day         (is_day),
        .center_x       (center_x),
        .center_y       (center_y),
        .red_total      (red_total),
        .logged_time    (logged_time)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/rbcl_pixel_reg.sv -----
// Input register that holds one pixel item until the tracker takes it.
`default_nettype none

module rbcl_pixel_reg
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire rbcl_pkg::pixel_t in_pixel,
    input  wire logic           advance,
    output logic                pix_valid,
    output rbcl_pkg::pixel_t    pix
);
    import rbcl_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    pixel_t pixel_reg;
    logic   accept;

    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign valid_next = accept ? 1'b1 : (advance ? 1'b0 : valid_reg);
    assign pix_valid  = valid_reg;
    assign pix        = pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pixel_reg <= in_pixel;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rbcl_tracker.sv -----
// Red pixel tracking state and the frame result register.
`default_nettype none

module rbcl_tracker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pix_valid,
    input  wire rbcl_pkg::pixel_t              pix,
    input  wire logic [rbcl_pkg::COUNT_W-1:0]  min_red_pixels,
    output logic                               advance,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               is_day,
    output logic [rbcl_pkg::COORD_W-1:0]       center_x,
    output logic [rbcl_pkg::COORD_W-1:0]       center_y,
    output logic [rbcl_pkg::COUNT_W-1:0]       red_total,
    output logic [rbcl_pkg::TIME_W-1:0]        logged_time
);
    import rbcl_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COORD_W-1:0] first_x_reg, first_x_next;
    logic [COORD_W-1:0] first_y_reg, first_y_next;
    logic [COORD_W-1:0] latest_x_reg, latest_x_next;
    logic [COORD_W-1:0] latest_y_reg, latest_y_next;
    logic               out_valid_reg, out_valid_next;
    logic               day_reg;
    logic [COORD_W-1:0] cx_reg;
    logic [COORD_W-1:0] cy_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [TIME_W-1:0]  time_reg;

    logic               is_red;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               out_free;
    logic               emit;
    logic               day;

    assign is_red   = ({1'b0, pix.red} > {pix.green, 1'b0}) &&
                      ({1'b0, pix.red} > {pix.blue, 1'b0});
    assign col      = clamp_coord(pix.column);
    assign row      = clamp_coord(pix.line);
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = pix_valid && (!pix.frame_end || out_free);
    assign emit     = advance && pix.frame_end;

    always_comb
    begin
        count_next    = count_reg;
        first_x_next  = first_x_reg;
        first_y_next  = first_y_reg;
        latest_x_next = latest_x_reg;
        latest_y_next = latest_y_reg;
        if (advance && is_red)
        begin
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            if (count_reg == '0)
            begin
                first_x_next = col;
                first_y_next = row;
            end
            else
            begin
                latest_x_next = col;
                latest_y_next = row;
            end
        end
    end

    assign day = count_next > min_red_pixels;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            latest_x_reg  <= '0;
            latest_y_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= emit ? '0 : count_next;
            first_x_reg   <= first_x_next;
            first_y_reg   <= first_y_next;
            latest_x_reg  <= latest_x_next;
            latest_y_reg  <= latest_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            day_reg   <= day;
            cx_reg    <= day ? midpoint(first_x_next, latest_x_next) : '0;
            cy_reg    <= day ? midpoint(first_y_next, latest_y_next) : '0;
            total_reg <= count_next;
            time_reg  <= pix.frame_time;
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_day      = day_reg;
    assign center_x    = cx_reg;
    assign center_y    = cy_reg;
    assign red_total   = total_reg;
    assign logged_time = time_reg;

endmodule

`default_nettype wire
